// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL of the transport connection block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk_s, rst_s, prop) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) \
    else $error("assertion failed: %m");

// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed: %m");

`endif

// File: rtl/tcf_pkg.sv
// Shared types, codes and widths of the transport connection state machine.
package tcf_pkg;

  localparam int TIME_W = 48;
  localparam int REG_W  = 24;
  localparam int FUNC_W = 3;
  localparam int TYPE_W = 8;
  localparam int LEN_W  = 16;
  localparam int CFG_IDX_W = 1;

  // Link states
  localparam logic [1:0] LINK_CONNECTED = 2'd0;
  localparam logic [1:0] LINK_AUTH      = 2'd1;
  localparam logic [1:0] LINK_DISC      = 2'd2;

  // Event codes
  localparam logic [2:0] FUNC_RECEIVE   = 3'd0;
  localparam logic [2:0] FUNC_TICK      = 3'd1;
  localparam logic [2:0] FUNC_APP_SEND  = 3'd2;
  localparam logic [2:0] FUNC_HANDSHAKE = 3'd3;
  localparam logic [2:0] FUNC_CLOSE     = 3'd4;

  // Received message types
  localparam logic [7:0] MSG_HANDSHAKE  = 8'd0;
  localparam logic [7:0] MSG_PING       = 8'd1;
  localparam logic [7:0] MSG_DATA       = 8'd2;
  localparam logic [7:0] MSG_DISCONNECT = 8'd3;

  // Sent message codes
  localparam logic [1:0] SEND_NONE      = 2'd0;
  localparam logic [1:0] SEND_HANDSHAKE = 2'd1;
  localparam logic [1:0] SEND_PING      = 2'd2;
  localparam logic [1:0] SEND_DATA      = 2'd3;

  // Disconnect causes
  localparam logic [2:0] CAUSE_NONE       = 3'd0;
  localparam logic [2:0] CAUSE_LOCAL      = 3'd1;
  localparam logic [2:0] CAUSE_UNEXPECTED = 3'd2;
  localparam logic [2:0] CAUSE_EMPTY_DATA = 3'd3;
  localparam logic [2:0] CAUSE_PEER       = 3'd4;
  localparam logic [2:0] CAUSE_TIMEOUT    = 3'd5;
  localparam logic [2:0] CAUSE_EMPTY_SEND = 3'd6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT       = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PING_INTERVAL = 1'd1;

  localparam logic [REG_W-1:0] TIMEOUT_RESET       = 24'd10000;
  localparam logic [REG_W-1:0] PING_INTERVAL_RESET = 24'd1000;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TIME_W-1:0] now_ms;
    logic [TYPE_W-1:0] msg_type;
    logic [LEN_W-1:0]  msg_length;
  } event_t;

  typedef struct packed {
    logic [1:0]        link;
    logic [TIME_W-1:0] last_rx;
    logic [TIME_W-1:0] last_ping;
  } link_ctx_t;

  typedef struct packed {
    logic [1:0] send_message;
    logic       send_disconnect;
    logic       deliver_data;
    logic       became_authenticated;
    logic       became_disconnected;
    logic [2:0] disconnect_cause;
    logic [1:0] conn_state;
  } result_t;

endpackage

// File: rtl/tcf_ifs.sv
// Request and result channel interfaces of the transport connection block.
interface tcf_req_if;
  logic                        valid;
  logic                        ready;
  logic [tcf_pkg::FUNC_W-1:0]  func;
  logic [tcf_pkg::TIME_W-1:0]  now_ms;
  logic [tcf_pkg::TYPE_W-1:0]  msg_type;
  logic [tcf_pkg::LEN_W-1:0]   msg_length;

  modport source (output valid, func, now_ms, msg_type, msg_length, input ready);
  modport sink (input valid, func, now_ms, msg_type, msg_length, output ready);
endinterface

interface tcf_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] send_message;
  logic       send_disconnect;
  logic       deliver_data;
  logic       became_authenticated;
  logic       became_disconnected;
  logic [2:0] disconnect_cause;
  logic [1:0] conn_state;

  modport source (output valid, send_message, send_disconnect, deliver_data,
                  became_authenticated, became_disconnected, disconnect_cause,
                  conn_state, input ready);
  modport sink (input valid, send_message, send_disconnect, deliver_data,
                became_authenticated, became_disconnected, disconnect_cause,
                conn_state, output ready);
endinterface

// File: rtl/tcf_step.sv
// Next-state and result logic for one event of the connection state machine.
module tcf_step (
  input  tcf_pkg::event_t                ev,
  input  tcf_pkg::link_ctx_t             cur,
  input  logic [tcf_pkg::REG_W-1:0]      timeout_ms,
  input  logic [tcf_pkg::REG_W-1:0]      ping_interval_ms,
  output tcf_pkg::link_ctx_t             nxt,
  output tcf_pkg::result_t               res
);

  logic [tcf_pkg::TIME_W:0] rx_deadline;
  logic [tcf_pkg::TIME_W:0] ping_due;
  logic                     timed_out;
  logic                     ping_now;
  logic                     close_req;
  logic [2:0]               close_cause;

  // Full-width sums, no wrap
  assign rx_deadline = {1'b0, cur.last_rx}
                     + {{(tcf_pkg::TIME_W + 1 - tcf_pkg::REG_W){1'b0}}, timeout_ms};
  assign ping_due    = {1'b0, cur.last_ping}
                     + {{(tcf_pkg::TIME_W + 1 - tcf_pkg::REG_W){1'b0}}, ping_interval_ms};
  assign timed_out   = {1'b0, ev.now_ms} >= rx_deadline;
  assign ping_now    = {1'b0, ev.now_ms} >= ping_due;

  always_comb begin
    nxt         = cur;
    res         = '0;
    close_req   = 1'b0;
    close_cause = tcf_pkg::CAUSE_NONE;

    unique case (ev.func)
      tcf_pkg::FUNC_RECEIVE: begin
        if (cur.link == tcf_pkg::LINK_CONNECTED && ev.msg_length != '0) begin
          if (ev.msg_type == tcf_pkg::MSG_HANDSHAKE) begin
            nxt.link                 = tcf_pkg::LINK_AUTH;
            nxt.last_rx              = ev.now_ms;
            res.became_authenticated = 1'b1;
          end else if (ev.msg_type <= tcf_pkg::MSG_DISCONNECT) begin
            close_req   = 1'b1;
            close_cause = tcf_pkg::CAUSE_UNEXPECTED;
          end
        end else if (cur.link == tcf_pkg::LINK_AUTH && ev.msg_length != '0) begin
          unique case (ev.msg_type)
            tcf_pkg::MSG_HANDSHAKE: begin
              close_req   = 1'b1;
              close_cause = tcf_pkg::CAUSE_UNEXPECTED;
            end
            tcf_pkg::MSG_PING: nxt.last_rx = ev.now_ms;
            tcf_pkg::MSG_DATA: begin
              if (ev.msg_length > 16'd1) begin
                nxt.last_rx      = ev.now_ms;
                res.deliver_data = 1'b1;
              end else begin
                close_req   = 1'b1;
                close_cause = tcf_pkg::CAUSE_EMPTY_DATA;
              end
            end
            tcf_pkg::MSG_DISCONNECT: begin
              close_req   = 1'b1;
              close_cause = tcf_pkg::CAUSE_PEER;
            end
            default: ;
          endcase
        end
      end
      tcf_pkg::FUNC_TICK: begin
        if (cur.link == tcf_pkg::LINK_AUTH && ping_now) begin
          res.send_message = tcf_pkg::SEND_PING;
          nxt.last_ping    = ev.now_ms;
        end
        if (timed_out) begin
          close_req   = 1'b1;
          close_cause = tcf_pkg::CAUSE_TIMEOUT;
        end
      end
      tcf_pkg::FUNC_APP_SEND: begin
        if (ev.msg_length == '0) begin
          close_req   = 1'b1;
          close_cause = tcf_pkg::CAUSE_EMPTY_SEND;
        end else begin
          res.send_message = tcf_pkg::SEND_DATA;
        end
      end
      tcf_pkg::FUNC_HANDSHAKE: res.send_message = tcf_pkg::SEND_HANDSHAKE;
      tcf_pkg::FUNC_CLOSE: begin
        close_req   = 1'b1;
        close_cause = tcf_pkg::CAUSE_LOCAL;
      end
      default: ;
    endcase

    // Close at most once
    if (close_req && cur.link != tcf_pkg::LINK_DISC) begin
      nxt.link                = tcf_pkg::LINK_DISC;
      res.send_disconnect     = 1'b1;
      res.became_disconnected = 1'b1;
      res.disconnect_cause    = close_cause;
    end

    res.conn_state = nxt.link;
  end

endmodule

// File: rtl/transport_connection_fsm_top.sv
// A request is held in the input register, then its result is held in the result register.
// Throughput: one request per cycle unless the result stage is stalled; the link state updates
//   as each request leaves the input register, so the following request sees it with no bubble.
// Reset (rst, synchronous, active high): link connected, both timestamps zero,
//   timeout 10000 ms, ping interval 1000 ms, both pipeline stages empty.
// Configuration writes take effect on the following cycle.
`include "assert_macros.svh"

module transport_connection_fsm_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [tcf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcf_pkg::REG_W-1:0]          cfg_data,
  tcf_req_if.sink                            req_ch,
  tcf_res_if.source                          res_ch
);

  // Configuration registers
  logic [tcf_pkg::REG_W-1:0] timeout_ms;
  logic [tcf_pkg::REG_W-1:0] ping_interval_ms;

  // Link context: state plus the two timestamps it compares against
  tcf_pkg::link_ctx_t ctx;
  tcf_pkg::link_ctx_t ctx_next;

  // Input stage holds one accepted request
  logic            ev_valid;
  tcf_pkg::event_t ev;

  // Result stage holds one finished result until the sink takes it
  logic             res_valid;
  tcf_pkg::result_t res;
  tcf_pkg::result_t res_next;

  logic res_free;
  logic advance;

  // The result stage frees up when empty or being drained this cycle
  assign res_free     = !res_valid || res_ch.ready;
  assign advance      = ev_valid && res_free;
  assign req_ch.ready = !ev_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms       <= tcf_pkg::TIMEOUT_RESET;
      ping_interval_ms <= tcf_pkg::PING_INTERVAL_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tcf_pkg::CFG_TIMEOUT:       timeout_ms       <= cfg_data;
        tcf_pkg::CFG_PING_INTERVAL: ping_interval_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture a new request whenever the input stage is empty or moving on
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (req_ch.ready) begin
      ev_valid <= req_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ch.ready && req_ch.valid) begin
      ev.func       <= req_ch.func;
      ev.now_ms     <= req_ch.now_ms;
      ev.msg_type   <= req_ch.msg_type;
      ev.msg_length <= req_ch.msg_length;
    end
  end

  tcf_step u_step (
    .ev               (ev),
    .cur              (ctx),
    .timeout_ms       (timeout_ms),
    .ping_interval_ms (ping_interval_ms),
    .nxt              (ctx_next),
    .res              (res_next)
  );

  // Commit the link context only when the request moves into the result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.link      <= tcf_pkg::LINK_CONNECTED;
      ctx.last_rx   <= '0;
      ctx.last_ping <= '0;
    end else if (advance) begin
      ctx <= ctx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign res_ch.valid                = res_valid;
  assign res_ch.send_message         = res.send_message;
  assign res_ch.send_disconnect      = res.send_disconnect;
  assign res_ch.deliver_data         = res.deliver_data;
  assign res_ch.became_authenticated = res.became_authenticated;
  assign res_ch.became_disconnected  = res.became_disconnected;
  assign res_ch.disconnect_cause     = res.disconnect_cause;
  assign res_ch.conn_state           = res.conn_state;

  // Once closed, the link stays closed until reset
  `ASSERT_NEXT(a_disc_sticky, clk, rst,
               ctx.link == tcf_pkg::LINK_DISC, ctx.link == tcf_pkg::LINK_DISC)
  // A request waiting in the input stage is never dropped while the result stage is stalled
  `ASSERT_NEXT(a_ev_held, clk, rst, ev_valid && !res_free, ev_valid && $stable(ev))
  // A reported close always leaves the link disconnected
  `ASSERT_ALWAYS(a_close_state, clk, rst,
                 !(res_valid && res.became_disconnected) || res.conn_state == tcf_pkg::LINK_DISC)
  // A cause is only given with a close
  `ASSERT_ALWAYS(a_cause_close, clk, rst,
                 !res_valid || res.became_disconnected || res.disconnect_cause == tcf_pkg::CAUSE_NONE)

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the transport connection state machine.
`timescale 1ns / 100ps

module testbench;

  // Func codes the block must ignore; they have no name in the package.
  localparam logic [tcf_pkg::FUNC_W-1:0] FUNC_RSVD5 = 3'd5;
  localparam logic [tcf_pkg::FUNC_W-1:0] FUNC_RSVD6 = 3'd6;
  localparam logic [tcf_pkg::FUNC_W-1:0] FUNC_RSVD7 = 3'd7;

  localparam logic [tcf_pkg::TIME_W-1:0] TIME_MAX = '1;
  localparam logic [tcf_pkg::REG_W-1:0]  REG_MAX  = '1;

  // Cycles with no request and no result moving before the run is declared hung.
  localparam int STALL_LIMIT = 1000;
  // Length of the long receiver hold-off, in cycles.
  localparam int HOLD_CYCLES = 64;

  // Outcomes that can be read straight off the spec for the opening rows.
  localparam tcf_pkg::result_t IDLE_CONNECTED =
    '{tcf_pkg::SEND_NONE, 1'b0, 1'b0, 1'b0, 1'b0, tcf_pkg::CAUSE_NONE,
      tcf_pkg::LINK_CONNECTED};
  localparam tcf_pkg::result_t DATA_SENT_CONNECTED =
    '{tcf_pkg::SEND_DATA, 1'b0, 1'b0, 1'b0, 1'b0, tcf_pkg::CAUSE_NONE,
      tcf_pkg::LINK_CONNECTED};
  localparam tcf_pkg::result_t HELLO_SENT_CONNECTED =
    '{tcf_pkg::SEND_HANDSHAKE, 1'b0, 1'b0, 1'b0, 1'b0, tcf_pkg::CAUSE_NONE,
      tcf_pkg::LINK_CONNECTED};
  localparam tcf_pkg::result_t LINK_UP =
    '{tcf_pkg::SEND_NONE, 1'b0, 1'b0, 1'b1, 1'b0, tcf_pkg::CAUSE_NONE,
      tcf_pkg::LINK_AUTH};

  typedef struct {
    tcf_pkg::event_t  ev;
    bit               typed;   // use res as written instead of the predicted outcome
    tcf_pkg::result_t res;
  } directed_row_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_wr_en;
  logic [tcf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tcf_pkg::REG_W-1:0]     cfg_data;

  tcf_req_if req_bus ();
  tcf_res_if res_bus ();

  transport_connection_fsm_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_ch    (req_bus),
    .res_ch    (res_bus)
  );

  // Shadow copy of the link: state, timestamps and timer registers.
  logic [1:0]                 link_st      = tcf_pkg::LINK_CONNECTED;
  logic [tcf_pkg::TIME_W-1:0] last_rx_ms   = '0;
  logic [tcf_pkg::TIME_W-1:0] last_ping_ms = '0;
  logic [tcf_pkg::REG_W-1:0]  timeout_reg  = tcf_pkg::TIMEOUT_RESET;
  logic [tcf_pkg::REG_W-1:0]  interval_reg = tcf_pkg::PING_INTERVAL_RESET;

  // Outcomes of accepted requests, oldest first.
  tcf_pkg::result_t pending_outcomes [$];
  int               mismatch_count = 0;

  // Local time of the random traffic; steps forward by a random amount, maybe zero, with each random request.
  logic [tcf_pkg::TIME_W-1:0] clock_ms;

  // Pacing controls shared by the sender, the receiver and the main sequence.
  // The sender flips hold_request to ask for a hold-off; the receiver tracks it.
  bit steady_send  = 1'b0;
  bit steady_recv  = 1'b0;
  bit hold_request = 1'b0;
  bit hold_seen    = 1'b0;
  int hold_left    = 0;
  int quiet_cycles = 0;

  // Opening rows: extremes, every func code except close, and the ignore cases while connected,
  // then the handshake and the authenticated behaviors that keep the link alive.
  directed_row_t opening_rows [$] = '{
    '{'{tcf_pkg::FUNC_TICK, 48'd0, 8'd0, 16'd0}, 1'b1, IDLE_CONNECTED},
    '{'{tcf_pkg::FUNC_RECEIVE, 48'd5, tcf_pkg::MSG_HANDSHAKE, 16'd0}, 1'b1, IDLE_CONNECTED},
    '{'{tcf_pkg::FUNC_RECEIVE, 48'd6, 8'hFF, 16'hFFFF}, 1'b1, IDLE_CONNECTED},
    '{'{tcf_pkg::FUNC_RECEIVE, 48'd7, 8'd4, 16'd1}, 1'b1, IDLE_CONNECTED},
    '{'{tcf_pkg::FUNC_APP_SEND, 48'd8, 8'd0, 16'hFFFF}, 1'b1, DATA_SENT_CONNECTED},
    '{'{tcf_pkg::FUNC_HANDSHAKE, 48'd9, 8'd0, 16'd0}, 1'b1, HELLO_SENT_CONNECTED},
    '{'{FUNC_RSVD5, 48'd10, 8'd0, 16'd0}, 1'b1, IDLE_CONNECTED},
    '{'{FUNC_RSVD6, TIME_MAX, 8'hFF, 16'hFFFF}, 1'b1, IDLE_CONNECTED},
    '{'{FUNC_RSVD7, 48'd11, 8'hFF, 16'd0}, 1'b1, IDLE_CONNECTED},
    '{'{tcf_pkg::FUNC_RECEIVE, 48'd100, tcf_pkg::MSG_HANDSHAKE, 16'd1}, 1'b1, LINK_UP},
    '{'{tcf_pkg::FUNC_RECEIVE, 48'd600, tcf_pkg::MSG_PING, 16'd1}, 1'b0, '0},
    '{'{tcf_pkg::FUNC_TICK, 48'd999, 8'd0, 16'd0}, 1'b0, '0},
    '{'{tcf_pkg::FUNC_TICK, 48'd1000, 8'd0, 16'd0}, 1'b0, '0},
    '{'{tcf_pkg::FUNC_RECEIVE, 48'd1500, tcf_pkg::MSG_DATA, 16'd2}, 1'b0, '0},
    '{'{tcf_pkg::FUNC_RECEIVE, 48'd1600, tcf_pkg::MSG_DATA, 16'hFFFF}, 1'b0, '0},
    '{'{tcf_pkg::FUNC_RECEIVE, 48'd1700, 8'd4, 16'd3}, 1'b0, '0},
    '{'{tcf_pkg::FUNC_RECEIVE, 48'd1800, 8'hFF, 16'd0}, 1'b0, '0},
    '{'{tcf_pkg::FUNC_RECEIVE, TIME_MAX, tcf_pkg::MSG_PING, 16'hFFFF}, 1'b0, '0},
    '{'{tcf_pkg::FUNC_TICK, 48'd1999, 8'd0, 16'd0}, 1'b0, '0},
    '{'{tcf_pkg::FUNC_RECEIVE, 48'd11000, tcf_pkg::MSG_PING, 16'd1}, 1'b0, '0},
    '{'{tcf_pkg::FUNC_TICK, 48'd20999, 8'd0, 16'd0}, 1'b0, '0},
    '{'{tcf_pkg::FUNC_APP_SEND, 48'd21000, 8'd0, 16'd1}, 1'b0, '0},
    '{'{tcf_pkg::FUNC_HANDSHAKE, 48'd21001, 8'd0, 16'd0}, 1'b0, '0}
  };

  // 20 ns clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Close the shadow link once; a second close leaves the result unchanged.
  function automatic void shut_link(inout tcf_pkg::result_t r, input logic [2:0] cause);
    if (link_st != tcf_pkg::LINK_DISC) begin
      r.send_disconnect     = 1'b1;
      r.became_disconnected = 1'b1;
      r.disconnect_cause    = cause;
      link_st               = tcf_pkg::LINK_DISC;
    end
  endfunction

  // Advance the shadow link by one request and return what the block must report.
  // Deadlines are formed one bit wider than the time so they never wrap.
  function automatic tcf_pkg::result_t step_link(input tcf_pkg::event_t ev);
    tcf_pkg::result_t         r;
    logic [tcf_pkg::TIME_W:0] rx_deadline;
    logic [tcf_pkg::TIME_W:0] ping_due;
    logic [tcf_pkg::TIME_W:0] stamp;
    r           = '0;
    stamp       = {1'b0, ev.now_ms};
    rx_deadline = {1'b0, last_rx_ms}
                + {{(tcf_pkg::TIME_W - tcf_pkg::REG_W + 1){1'b0}}, timeout_reg};
    ping_due    = {1'b0, last_ping_ms}
                + {{(tcf_pkg::TIME_W - tcf_pkg::REG_W + 1){1'b0}}, interval_reg};
    case (ev.func)
      tcf_pkg::FUNC_RECEIVE: begin
        if (link_st != tcf_pkg::LINK_DISC && ev.msg_length != '0) begin
          if (link_st == tcf_pkg::LINK_CONNECTED) begin
            if (ev.msg_type == tcf_pkg::MSG_HANDSHAKE) begin
              link_st                = tcf_pkg::LINK_AUTH;
              last_rx_ms             = ev.now_ms;
              r.became_authenticated = 1'b1;
            end else if (ev.msg_type <= tcf_pkg::MSG_DISCONNECT) begin
              shut_link(r, tcf_pkg::CAUSE_UNEXPECTED);
            end
          end else begin
            case (ev.msg_type)
              tcf_pkg::MSG_HANDSHAKE: shut_link(r, tcf_pkg::CAUSE_UNEXPECTED);
              tcf_pkg::MSG_PING: last_rx_ms = ev.now_ms;
              tcf_pkg::MSG_DATA: begin
                // One byte is the type alone: empty data drops the link.
                if (ev.msg_length > 16'd1) begin
                  last_rx_ms     = ev.now_ms;
                  r.deliver_data = 1'b1;
                end else begin
                  shut_link(r, tcf_pkg::CAUSE_EMPTY_DATA);
                end
              end
              tcf_pkg::MSG_DISCONNECT: shut_link(r, tcf_pkg::CAUSE_PEER);
              default: ;
            endcase
          end
        end
      end
      tcf_pkg::FUNC_TICK: begin
        if (link_st != tcf_pkg::LINK_DISC) begin
          if (link_st == tcf_pkg::LINK_AUTH && stamp >= ping_due) begin
            r.send_message = tcf_pkg::SEND_PING;
            last_ping_ms   = ev.now_ms;
          end
          if (stamp >= rx_deadline) shut_link(r, tcf_pkg::CAUSE_TIMEOUT);
        end
      end
      tcf_pkg::FUNC_APP_SEND: begin
        if (ev.msg_length == '0) shut_link(r, tcf_pkg::CAUSE_EMPTY_SEND);
        else r.send_message = tcf_pkg::SEND_DATA;
      end
      tcf_pkg::FUNC_HANDSHAKE: r.send_message = tcf_pkg::SEND_HANDSHAKE;
      tcf_pkg::FUNC_CLOSE: shut_link(r, tcf_pkg::CAUSE_LOCAL);
      default: ;
    endcase
    r.conn_state = link_st;
    return r;
  endfunction

  // Start of a fresh random time base with the two top bits given.
  function automatic logic [tcf_pkg::TIME_W-1:0] fresh_base(input logic [1:0] top);
    logic [63:0] raw;
    raw        = {$urandom, $urandom};
    raw[47:46] = top;
    raw[7:0]   = '0;
    return raw[tcf_pkg::TIME_W-1:0];
  endfunction

  // Mostly traffic that keeps the link alive; closing requests only when allowed,
  // and then rarely, so the link survives deep into the phase.
  function automatic tcf_pkg::event_t random_event(input bit allow_close);
    tcf_pkg::event_t ev;
    int unsigned     pick;
    ev.func       = tcf_pkg::FUNC_TICK;
    ev.msg_type   = 8'($urandom_range(255));
    ev.msg_length = 16'($urandom_range(16'hFFFF));
    pick          = $urandom_range(999);
    clock_ms      = clock_ms + $urandom_range(400);
    if (pick < 350) begin
      ev.func = tcf_pkg::FUNC_TICK;
    end else if (pick < 500) begin
      ev.func       = tcf_pkg::FUNC_RECEIVE;
      ev.msg_type   = tcf_pkg::MSG_PING;
      ev.msg_length = 16'($urandom_range(16'hFFFF, 1));
    end else if (pick < 650) begin
      ev.func       = tcf_pkg::FUNC_RECEIVE;
      ev.msg_type   = tcf_pkg::MSG_DATA;
      ev.msg_length = 16'($urandom_range(16'hFFFF, 2));
    end else if (pick < 700) begin
      ev.func       = tcf_pkg::FUNC_RECEIVE;
      ev.msg_type   = 8'($urandom_range(255, 4));
    end else if (pick < 730) begin
      ev.func       = tcf_pkg::FUNC_RECEIVE;
      ev.msg_length = '0;
    end else if (pick < 820) begin
      ev.func       = tcf_pkg::FUNC_APP_SEND;
      ev.msg_length = 16'($urandom_range(16'hFFFF, 1));
    end else if (pick < 880) begin
      ev.func = tcf_pkg::FUNC_HANDSHAKE;
    end else if (pick < 910) begin
      ev.func = 3'($urandom_range(FUNC_RSVD7, FUNC_RSVD5));
    end else if (pick >= 990 && allow_close) begin
      case ($urandom_range(5))
        0: begin
          ev.func       = tcf_pkg::FUNC_RECEIVE;
          ev.msg_type   = tcf_pkg::MSG_DATA;
          ev.msg_length = 16'd1;
        end
        1: begin
          ev.func       = tcf_pkg::FUNC_RECEIVE;
          ev.msg_type   = tcf_pkg::MSG_DISCONNECT;
          ev.msg_length = 16'($urandom_range(16'hFFFF, 1));
        end
        2: begin
          ev.func       = tcf_pkg::FUNC_RECEIVE;
          ev.msg_type   = tcf_pkg::MSG_HANDSHAKE;
          ev.msg_length = 16'($urandom_range(16'hFFFF, 1));
        end
        3: ev.func = tcf_pkg::FUNC_CLOSE;
        4: begin
          ev.func       = tcf_pkg::FUNC_APP_SEND;
          ev.msg_length = '0;
        end
        default: begin
          // Stay silent past the receive timeout, then tick.
          clock_ms = clock_ms + timeout_reg + $urandom_range(3);
          ev.func  = tcf_pkg::FUNC_TICK;
        end
      endcase
    end
    ev.now_ms = clock_ms;
    return ev;
  endfunction

  // Offer one request, hold it until accepted, then queue its outcome.
  task automatic offer_request(input tcf_pkg::event_t ev, input bit typed,
                               input tcf_pkg::result_t typed_res);
    tcf_pkg::result_t predicted;
    while (!steady_send && $urandom_range(99) < 31) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid      <= 1'b1;
    req_bus.func       <= ev.func;
    req_bus.now_ms     <= ev.now_ms;
    req_bus.msg_type   <= ev.msg_type;
    req_bus.msg_length <= ev.msg_length;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    predicted = step_link(ev);
    pending_outcomes.push_back(typed ? typed_res : predicted);
  endtask

  // Stop offering and wait for every outstanding result.
  task automatic drain();
    req_bus.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // Write both timer registers on back-to-back cycles; only call while idle.
  task automatic program_link_timers(input logic [tcf_pkg::REG_W-1:0] timeout_val,
                                     input logic [tcf_pkg::REG_W-1:0] interval_val);
    cfg_wr_en <= 1'b1;
    cfg_index <= tcf_pkg::CFG_TIMEOUT;
    cfg_data  <= timeout_val;
    @(posedge clk);
    cfg_index <= tcf_pkg::CFG_PING_INTERVAL;
    cfg_data  <= interval_val;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    timeout_reg  = timeout_val;
    interval_reg = interval_val;
  endtask

  // One random phase: refresh liveness at the current time, then random traffic.
  // With with_hold, stall the receiver for a long stretch while the sender keeps
  // offering back to back, so the pipeline fills and backs up into the input.
  task automatic run_phase(input int count, input bit allow_close, input bit with_hold);
    tcf_pkg::event_t ev;
    ev            = '0;
    ev.func       = tcf_pkg::FUNC_RECEIVE;
    ev.msg_type   = tcf_pkg::MSG_PING;
    ev.msg_length = 16'd1;
    ev.now_ms     = clock_ms;
    offer_request(ev, 1'b0, '0);
    for (int i = 1; i < count; i++) begin
      if (with_hold && i == count / 4) begin
        hold_request <= !hold_request;
        steady_send  = 1'b1;
      end
      if (with_hold && i == count / 4 + 40) steady_send = 1'b0;
      offer_request(random_event(allow_close), 1'b0, '0);
    end
    drain();
  endtask

  // Main sequence.
  initial begin
    // Drive every block input to a known value from time zero.
    rst                <= 1'b1;
    cfg_wr_en          <= 1'b0;
    cfg_index          <= tcf_pkg::CFG_TIMEOUT;
    cfg_data           <= '0;
    req_bus.valid      <= 1'b0;
    req_bus.func       <= tcf_pkg::FUNC_RECEIVE;
    req_bus.now_ms     <= '0;
    req_bus.msg_type   <= tcf_pkg::MSG_HANDSHAKE;
    req_bus.msg_length <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Walk the opening table with the reset timer values.
    foreach (opening_rows[i])
      offer_request(opening_rows[i].ev, opening_rows[i].typed, opening_rows[i].res);
    drain();

    // Longest timeout, ping on every tick; includes the long receiver hold-off.
    program_link_timers(REG_MAX, '0);
    clock_ms = fresh_base(2'b00);
    run_phase(120, 1'b0, 1'b1);

    // Large timeout and the longest ping interval; no idling on either side.
    program_link_timers(24'($urandom_range(REG_MAX - 1, 50000)), REG_MAX);
    clock_ms    = fresh_base(2'b01);
    steady_send = 1'b1;
    steady_recv = 1'b1;
    run_phase(120, 1'b0, 1'b0);
    steady_send = 1'b0;
    steady_recv = 1'b0;

    // Moderate timers; closing requests may now end the link.
    program_link_timers(24'($urandom_range(60000, 20000)), 24'($urandom_range(999, 1)));
    clock_ms = fresh_base({1'b1, 1'($urandom_range(1))});
    run_phase(160, 1'b1, 1'b0);

    // Zero timeout: any tick on a live link closes it.
    program_link_timers('0, 24'($urandom_range(REG_MAX)));
    run_phase(40, 1'b1, 1'b0);

    // Let any stray result show up before the verdict.
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result side: random back-pressure, plus the counted hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (hold_request != hold_seen) begin
        hold_seen = hold_request;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= steady_recv || ($urandom_range(99) >= 31);
      end
    end
  end

  task automatic compare_field(input string field, input logic [2:0] want,
                               input logic [2:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // Check each accepted result against the oldest queued outcome.
  always @(posedge clk) begin
    tcf_pkg::result_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (pending_outcomes.size() == 0) begin
        mismatch_count++;
        $display("%0t: result expected none, got one (conn_state %0d)",
                 $time, res_bus.conn_state);
      end else begin
        want = pending_outcomes.pop_front();
        compare_field("send_message", 3'(want.send_message), 3'(res_bus.send_message));
        compare_field("send_disconnect", 3'(want.send_disconnect),
                      3'(res_bus.send_disconnect));
        compare_field("deliver_data", 3'(want.deliver_data), 3'(res_bus.deliver_data));
        compare_field("became_authenticated", 3'(want.became_authenticated),
                      3'(res_bus.became_authenticated));
        compare_field("became_disconnected", 3'(want.became_disconnected),
                      3'(res_bus.became_disconnected));
        compare_field("disconnect_cause", want.disconnect_cause, res_bus.disconnect_cause);
        compare_field("conn_state", 3'(want.conn_state), 3'(res_bus.conn_state));
      end
    end
  end

  // Watchdog: drop the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule
